/* design/mcls_pkg.sv */
// shared types, codes and helpers of the monte carlo walk unit
// no dependencies
`default_nettype none
package mcls_pkg;

  // input item modes
  localparam logic [1:0] MODE_MAT   = 2'd0;
  localparam logic [1:0] MODE_RHS   = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_DRAW  = 2'd3;

  // register indexes on the config port
  localparam logic [1:0] REG_STOP   = 2'd0;
  localparam logic [1:0] REG_WALKS  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // divider operand selection
  localparam logic [1:0] DIV_WEIGHT = 2'd0;
  localparam logic [1:0] DIV_ABSORB = 2'd1;
  localparam logic [1:0] DIV_MEAN   = 2'd2;

  localparam int DIV_W = 64;
  localparam int DVS_W = 16;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic [15:0]        random;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic [3:0]         estimate_row;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [15:0] stop_probability;
    logic [15:0] walks_per_row;
    logic [24:0] zero_threshold;
  } cfg_t;

  typedef struct packed {
    logic       load_item;
    logic       scan_clear;
    logic       scan_run;
    logic       scan_pick;
    logic       mul_load;
    logic       mul_rhs;
    logic       mul_nnz;
    logic       div_start;
    logic [1:0] div_sel;
    logic       w_update;
    logic       acc_add;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic absorb_draw;
    logic scan_done;
    logic nnz_zero;
    logic pick_found;
    logic div_done;
    logic walks_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_res_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(32'd0 - v) : v;
  endfunction

  // saturate a sign and magnitude to 32-bit two's complement
  function automatic sat_res_t sat32(input logic neg, input logic [63:0] m);
    sat_res_t r;
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = m[31:0];
        r.sat = 1'b0;
      end
    end else begin
      if (m >= 64'h8000_0000) begin
        r.val = 32'h8000_0000;
        r.sat = (m != 64'h8000_0000);
      end else begin
        r.val = 32'(32'd0 - m[31:0]);
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/monte_carlo_linear_solver_walk_unit.sv */
// top level of the monte carlo walk unit: config registers and wiring
// uses mcls_pkg, mcls_ctrl, mcls_datapath (which holds mcls_ram, mcls_div)
`default_nettype none
// Estimates one component x[i] of A x = b by absorbing random walks. Matrix
// items store L = I - A, rhs items fill b, a start item opens a row and draw
// items drive the walks; after walks_per_row absorbed walks one result with
// the mean leaves on the output channel. Matrix, rhs and start items are
// loaded in the idle state without leaving it. A draw that moves the walk
// makes two passes over the current matrix row through the single ram read
// port (count of nonzero entries, then the column choice), multiplies, and
// a division in the shared bit-serial divider. An absorbing draw spends all
// but a little of its time in the divider, and the draw that ends the last
// walk adds one more division for the mean. The result sits in an output
// register, so the next item is taken while it waits for transfer. Both
// stores start undefined: entries must be written before a walk reads them.
module monte_carlo_linear_solver_walk_unit #(
  parameter int SIZE_N    = 16,
  parameter int FRAC_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // item input
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire mcls_pkg::in_item_t  in_data,
  // result output
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      mcls_pkg::out_item_t out_data,
  // config port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);
  import mcls_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_probability <= 16'd3277;
      cfg.walks_per_row    <= 16'd1000;
      cfg.zero_threshold   <= 25'd1678;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_STOP:   cfg.stop_probability <= pwdata[15:0];
        REG_WALKS:  cfg.walks_per_row    <= pwdata[15:0];
        REG_THRESH: cfg.zero_threshold   <= pwdata[24:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_STOP:   prdata = {16'd0, cfg.stop_probability};
      REG_WALKS:  prdata = {16'd0, cfg.walks_per_row};
      REG_THRESH: prdata = {7'd0, cfg.zero_threshold};
      default:    prdata = 32'd0;
    endcase
  end

  // sequencer
  mcls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, scan and arithmetic
  mcls_datapath #(.SIZE_N(SIZE_N), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

/* design/mcls_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module mcls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/mcls_div.sv */
// iterative restoring divider, one quotient bit per cycle
// uses mcls_pkg
`default_nettype none
module mcls_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [mcls_pkg::DIV_W-1:0] dividend,
  input  wire logic [mcls_pkg::DVS_W-1:0] divisor,
  output      logic [mcls_pkg::DIV_W-1:0] quotient,
  output      logic                      done
);
  import mcls_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quotient <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= DVS_W'(trial - {1'b0, dvs});
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= trial[DVS_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/mcls_datapath.sv */
// walk datapath: matrix and rhs stores, row scan, weight and sum arithmetic
// uses mcls_pkg, mcls_ram, mcls_div
`default_nettype none
module mcls_datapath #(
  parameter int SIZE_N    = 16,
  parameter int FRAC_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcls_pkg::cfg_t      cfg,
  input  wire mcls_pkg::cmd_t      cmd,
  input  wire mcls_pkg::in_item_t  in_data,
  output      mcls_pkg::sts_t      sts,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      mcls_pkg::out_item_t out_data
);
  import mcls_pkg::*;

  localparam int IDX_W = $clog2(SIZE_N);
  localparam int NNZ_W = $clog2(SIZE_N + 1);
  localparam int AW    = $clog2(SIZE_N * SIZE_N);
  localparam int CMP_W = 16 + NNZ_W;
  localparam int WT_W  = 33 + NNZ_W;
  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

  // config with zero acting as one
  logic [15:0] p_eff, walks_eff, q;
  assign p_eff     = (cfg.stop_probability == 16'd0) ? 16'd1 : cfg.stop_probability;
  assign walks_eff = (cfg.walks_per_row == 16'd0) ? 16'd1 : cfg.walks_per_row;
  assign q         = 16'(17'h1_0000 - {1'b0, p_eff});

  // walk state
  logic                busy, sat_flag;
  logic [IDX_W-1:0]    start_row, current_row;
  logic [31:0]         weight;
  logic signed [47:0]  sum;
  logic [15:0]         walk_count;
  logic [15:0]         r_draw;

  // item decode
  logic row_ok, col_ok, mat_we, rhs_we;
  logic [IDX_W-1:0] row_ix, col_ix;
  assign row_ok = {28'd0, in_data.row} < 32'(SIZE_N);
  assign col_ok = {28'd0, in_data.col} < 32'(SIZE_N);
  assign row_ix = IDX_W'(in_data.row);
  assign col_ix = IDX_W'(in_data.col);
  assign mat_we = cmd.load_item && in_data.mode == MODE_MAT && row_ok && col_ok;
  assign rhs_we = cmd.load_item && in_data.mode == MODE_RHS && row_ok;

  // stored form is L = I - A, saturated
  logic signed [33:0] lv;
  logic [33:0]        lv_mag;
  sat_res_t           lv_sat;
  always_comb begin
    if (in_data.row == in_data.col) begin
      lv = $signed({2'b00, ONE_Q}) - {{2{in_data.value[31]}}, in_data.value};
    end else begin
      lv = 34'sd0 - {{2{in_data.value[31]}}, in_data.value};
    end
    lv_mag = lv[33] ? 34'(34'sd0 - lv) : 34'(lv);
    lv_sat = sat32(lv[33], 64'(lv_mag));
  end

  // scan state
  logic [IDX_W:0]   k;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [NNZ_W-1:0] nnz, jcnt, jnext;
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;
  logic [31:0]      pick_val;

  logic [AW-1:0] mat_waddr, mat_raddr;
  logic [31:0]   mat_q, rhs_q;
  assign mat_waddr = AW'(row_ix) * AW'(SIZE_N) + AW'(col_ix);
  assign mat_raddr = AW'(current_row) * AW'(SIZE_N) + AW'(k[IDX_W-1:0]);

  mcls_ram #(.WIDTH(32), .DEPTH(SIZE_N * SIZE_N)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (lv_sat.val),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  mcls_ram #(.WIDTH(32), .DEPTH(SIZE_N)) u_rhs (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (row_ix),
    .wdata (in_data.value),
    .raddr (current_row),
    .rdata (rhs_q)
  );

  logic nz, pick_hit;
  assign nz       = mag32(mat_q) > {7'd0, cfg.zero_threshold};
  assign jnext    = jcnt + 1'b1;
  assign pick_hit = CMP_W'(r_draw) * CMP_W'(nnz) <= CMP_W'(q) * CMP_W'(jnext);

  // multiply and divide
  logic [63:0]       prod, tshift, dvd, quot;
  logic [15:0]       dvs;
  logic              neg;
  logic [WT_W-1:0]   wt;
  logic [32:0]       t33;
  logic [47:0]       t48;
  logic [48:0]       ta;
  logic [31:0]       mul_x;
  logic [47:0]       sum_mag;
  logic              div_done;

  assign mul_x   = cmd.mul_rhs ? rhs_q : pick_val;
  assign tshift  = prod >> FRAC_BITS;
  assign t33     = (tshift > 64'h1_0000_0000) ? 33'h1_0000_0000 : tshift[32:0];
  assign t48     = (tshift > (64'd1 << 47)) ? 48'h8000_0000_0000 : tshift[47:0];
  assign ta      = (quot > (64'd1 << 48)) ? 49'h1_0000_0000_0000 : quot[48:0];
  assign sum_mag = sum[47] ? 48'(48'sd0 - sum) : 48'(sum);

  always_comb begin
    case (cmd.div_sel)
      DIV_WEIGHT: begin
        dvd = 64'(wt) << 16;
        dvs = q;
      end
      DIV_ABSORB: begin
        dvd = {t48, 16'd0};
        dvs = p_eff;
      end
      DIV_MEAN: begin
        dvd = 64'(sum_mag);
        dvs = walks_eff;
      end
      default: begin
        dvd = '0;
        dvs = 16'd1;
      end
    endcase
  end

  mcls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quot),
    .done     (div_done)
  );

  sat_res_t w_sat, m_sat;
  logic signed [49:0] s50;
  assign w_sat = sat32(neg && quot != 64'd0, quot);
  assign m_sat = sat32(sum[47], quot);
  assign s50   = neg ? ({{2{sum[47]}}, sum} - $signed({1'b0, ta}))
                     : ({{2{sum[47]}}, sum} + $signed({1'b0, ta}));

  // scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      k          <= '0;
      rd_vld     <= 1'b0;
      jcnt       <= '0;
      pick_found <= 1'b0;
      if (!cmd.scan_pick) begin
        nnz <= '0;
      end
    end else if (cmd.scan_run) begin
      if (k < (IDX_W+1)'(SIZE_N)) begin
        k      <= k + 1'b1;
        rd_vld <= 1'b1;
        rd_idx <= k[IDX_W-1:0];
      end else begin
        rd_vld <= 1'b0;
      end
      if (rd_vld && nz) begin
        if (!cmd.scan_pick) begin
          nnz <= nnz + 1'b1;
        end else if (!pick_found) begin
          jcnt <= jnext;
          if (pick_hit) begin
            pick_found <= 1'b1;
            pick_idx   <= rd_idx;
            pick_val   <= mat_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= 64'(mag32(weight)) * 64'(mag32(mul_x));
      neg  <= weight[31] ^ mul_x[31];
    end
    if (cmd.mul_nnz) begin
      wt <= WT_W'(t33) * WT_W'(nnz);
    end
  end

  // walk state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      sat_flag    <= 1'b0;
      start_row   <= '0;
      current_row <= '0;
      weight      <= ONE_Q;
      sum         <= '0;
      walk_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.out_load) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_item) begin
        if (in_data.mode == MODE_START && row_ok) begin
          start_row   <= row_ix;
          current_row <= row_ix;
          weight      <= ONE_Q;
          sum         <= '0;
          walk_count  <= '0;
          busy        <= 1'b1;
          sat_flag    <= 1'b0;
        end
        if (in_data.mode == MODE_DRAW) begin
          r_draw <= in_data.random;
        end
      end
      if (cmd.w_update) begin
        weight      <= w_sat.val;
        sat_flag    <= sat_flag | w_sat.sat;
        current_row <= pick_idx;
      end
      if (cmd.acc_add) begin
        if (s50 > 50'sh7FFF_FFFF_FFFF) begin
          sum      <= 48'sh7FFF_FFFF_FFFF;
          sat_flag <= 1'b1;
        end else if (s50 < -50'sh8000_0000_0000) begin
          sum      <= 48'sh8000_0000_0000;
          sat_flag <= 1'b1;
        end else begin
          sum <= 48'(s50);
        end
        walk_count  <= walk_count + 1'b1;
        weight      <= ONE_Q;
        current_row <= start_row;
      end
      if (cmd.out_load) begin
        out_valid             <= 1'b1;
        out_data.estimate     <= m_sat.val;
        out_data.estimate_row <= 4'(start_row);
        out_data.saturated    <= sat_flag | m_sat.sat;
        sat_flag              <= sat_flag | m_sat.sat;
        busy                  <= 1'b0;
      end
    end
  end

  assign sts.busy        = busy;
  assign sts.absorb_draw = r_draw >= q;
  assign sts.scan_done   = rd_vld && rd_idx == IDX_W'(SIZE_N - 1);
  assign sts.nnz_zero    = nnz == '0;
  assign sts.pick_found  = pick_found;
  assign sts.div_done    = div_done;
  assign sts.walks_done  = walk_count >= walks_eff;
  assign sts.out_free    = !out_valid || !out_stall;
endmodule
`default_nettype wire

/* design/mcls_ctrl.sv */
// walk controller state machine, sequences the datapath per item
// uses mcls_pkg
`default_nettype none
module mcls_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_mode,
  output      logic           in_stall,
  input  wire mcls_pkg::sts_t sts,
  output      mcls_pkg::cmd_t cmd
);
  import mcls_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DRAW = 4'd1;
  localparam logic [3:0] S_CNT  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_PICK = 4'd4;
  localparam logic [3:0] S_PCHK = 4'd5;
  localparam logic [3:0] S_WNZ  = 4'd6;
  localparam logic [3:0] S_WDS  = 4'd7;
  localparam logic [3:0] S_WDW  = 4'd8;
  localparam logic [3:0] S_ABS  = 4'd9;
  localparam logic [3:0] S_ADS  = 4'd10;
  localparam logic [3:0] S_ADW  = 4'd11;
  localparam logic [3:0] S_AFIN = 4'd12;
  localparam logic [3:0] S_MDW  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_mode == MODE_DRAW && sts.busy) begin
            state_next = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (sts.absorb_draw) begin
          state_next = S_ABS;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_CNT;
        end
      end
      S_CNT: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.nnz_zero) begin
          state_next = S_ABS;
        end else begin
          cmd.scan_clear = 1'b1;
          cmd.scan_pick  = 1'b1;
          state_next     = S_PICK;
        end
      end
      S_PICK: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_pick = 1'b1;
        if (sts.scan_done) begin
          state_next = S_PCHK;
        end
      end
      S_PCHK: begin
        if (!sts.pick_found) begin
          state_next = S_ABS;
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = S_WNZ;
        end
      end
      S_WNZ: begin
        cmd.mul_nnz = 1'b1;
        state_next  = S_WDS;
      end
      S_WDS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WEIGHT;
        state_next    = S_WDW;
      end
      S_WDW: begin
        if (sts.div_done) begin
          cmd.w_update = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ABS: begin
        cmd.mul_load = 1'b1;
        cmd.mul_rhs  = 1'b1;
        state_next   = S_ADS;
      end
      S_ADS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ABSORB;
        state_next    = S_ADW;
      end
      S_ADW: begin
        if (sts.div_done) begin
          cmd.acc_add = 1'b1;
          state_next  = S_AFIN;
        end
      end
      S_AFIN: begin
        if (sts.walks_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_next    = S_MDW;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MDW: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
